FILE: sv/rvs_pkg.sv
// Package for the radial vignette shader.
// Holds shared types, widths and fixed-point constants; no dependencies.
`default_nettype none
package rvs_pkg;

  localparam int MAX_SIDE    = 4096;
  localparam int DIV_STAGES  = 32;
  localparam int SQRT_STAGES = 17;

  localparam logic [16:0] ONE_Q16     = 17'h10000;
  localparam logic [16:0] HALF_Q16    = 17'h08000;
  localparam logic [13:0] DIST_SCALE  = 14'd10000;
  localparam logic [23:0] ROUND_PCT   = 24'd50;
  // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x < 2^23
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_STRENGTH = 2'd2,
    REG_RADIUS   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [6:0]  strength;
    logic [7:0]  radius;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  typedef struct packed {
    logic        valid;
    logic        sat;
    logic [41:0] den;
    logic [42:0] rem;
    logic [33:0] quo;
    pix_t        pix;
  } div_t;

  typedef struct packed {
    logic        valid;
    logic        sat;
    logic [33:0] rad;
    logic [18:0] rem;
    logic [16:0] root;
    pix_t        pix;
  } sqr_t;

endpackage
`default_nettype wire

FILE: sv/radial_vignette_shader.sv
// Radial vignette shader, top level: config registers and pipeline glue.
// Pipeline stages: 6 front, 32 divide, 17 root, 4 gain; one pixel per
// cycle, the whole pipeline holds while result_stall is high and a result
// waits. Reset clears all stage valid bits and loads the default config.
// Uses rvs_pkg, rvs_front, rvs_divider, rvs_sqrt, rvs_gain.
`default_nettype none
module radial_vignette_shader (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  input  wire logic        pixel_valid,
  output logic             pixel_stall,
  input  wire logic [11:0] column,
  input  wire logic [11:0] row,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic [7:0]  in_alpha,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha
);

  rvs_pkg::cfg_t cfg;
  rvs_pkg::pix_t pix;
  rvs_pkg::div_t front_out, div_out;
  rvs_pkg::sqr_t sqrt_out;
  logic          en;

  assign cfg_ready   = 1'b1;
  assign en          = !result_valid || !result_stall;
  assign pixel_stall = !en;
  assign pix = '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= 13'd640;
      cfg.height   <= 13'd480;
      cfg.strength <= 7'd50;
      cfg.radius   <= 8'd75;
    end else if (cfg_valid && cfg_ready) begin
      case (rvs_pkg::reg_index_t'(cfg_index))
        rvs_pkg::REG_WIDTH:    cfg.width    <= cfg_data;
        rvs_pkg::REG_HEIGHT:   cfg.height   <= cfg_data;
        rvs_pkg::REG_STRENGTH: cfg.strength <= cfg_data[6:0];
        rvs_pkg::REG_RADIUS:   cfg.radius   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rvs_front u_front (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .pix_valid(pixel_valid), .column(column), .row(row), .pix(pix),
    .dout(front_out)
  );

  rvs_divider u_divider (
    .clk(clk), .rst(rst), .en(en), .din(front_out), .dout(div_out)
  );

  rvs_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en), .din(div_out), .dout(sqrt_out)
  );

  rvs_gain u_gain (
    .clk(clk), .rst(rst), .en(en), .strength(cfg.strength), .din(sqrt_out),
    .result_valid(result_valid), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .out_alpha(out_alpha)
  );

endmodule
`default_nettype wire

FILE: sv/rvs_front.sv
// Front end: centre distances, squared distance and reference, saturation
// test and the two integer quotient bits. Uses rvs_pkg.
`default_nettype none
module rvs_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire rvs_pkg::cfg_t cfg,
  input  wire logic         pix_valid,
  input  wire logic [11:0]  column,
  input  wire logic [11:0]  row,
  input  wire rvs_pkg::pix_t pix,
  output rvs_pkg::div_t     dout
);

  logic [12:0] w, h, col2, row2, dx, dy;
  logic [25:0] wsq, hsq, dxsq, dysq;
  logic [15:0] rsq;
  logic [43:0] num_ext, den4_ext;
  logic [42:0] den2_ext, rem_a;
  logic        bit_hi, bit_lo;

  logic        v1, v2, v3, v4, v5;
  logic [12:0] dx1, dy1;
  logic [24:0] wsq1, hsq1;
  logic [15:0] rsq1, rsq2;
  logic [25:0] dxsq2, dysq2, sumwh2;
  logic [26:0] dsum3;
  logic [41:0] den3, den4, den5;
  logic [40:0] num4;
  logic        sat5, q1_5;
  logic [42:0] rem5;
  rvs_pkg::pix_t pix1, pix2, pix3, pix4, pix5;

  always_comb begin
    w = (cfg.width == 13'd0) ? 13'd1 :
        (cfg.width > 13'(rvs_pkg::MAX_SIDE)) ? 13'(rvs_pkg::MAX_SIDE) : cfg.width;
    h = (cfg.height == 13'd0) ? 13'd1 :
        (cfg.height > 13'(rvs_pkg::MAX_SIDE)) ? 13'(rvs_pkg::MAX_SIDE) : cfg.height;
    col2 = {column, 1'b0};
    row2 = {row, 1'b0};
    dx = (col2 >= w) ? col2 - w : w - col2;
    dy = (row2 >= h) ? row2 - h : h - row2;
    wsq = 26'(w) * 26'(w);
    hsq = 26'(h) * 26'(h);
    rsq = 16'(cfg.radius) * 16'(cfg.radius);
    dxsq = 26'(dx1) * 26'(dx1);
    dysq = 26'(dy1) * 26'(dy1);
    num_ext  = {3'b000, num4};
    den4_ext = {den4, 2'b00};
    den2_ext = {den4, 1'b0};
    bit_hi   = (43'(num4) >= den2_ext);
    rem_a    = bit_hi ? 43'(num4) - den2_ext : 43'(num4);
    bit_lo   = (rem5 >= 43'(den5));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      dout.valid <= 1'b0;
    end else if (en) begin
      v1 <= pix_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      dout.valid <= v5;

      dx1 <= dx;
      dy1 <= dy;
      wsq1 <= wsq[24:0];
      hsq1 <= hsq[24:0];
      rsq1 <= rsq;
      pix1 <= pix;

      dxsq2 <= dxsq;
      dysq2 <= dysq;
      sumwh2 <= 26'(wsq1) + 26'(hsq1);
      rsq2 <= rsq1;
      pix2 <= pix1;

      dsum3 <= 27'(dxsq2) + 27'(dysq2);
      den3 <= 42'(sumwh2) * 42'(rsq2);
      pix3 <= pix2;

      num4 <= 41'(dsum3) * 41'(rvs_pkg::DIST_SCALE);
      den4 <= den3;
      pix4 <= pix3;

      sat5 <= (den4 == 42'd0) || (num_ext >= den4_ext);
      q1_5 <= bit_hi;
      rem5 <= rem_a;
      den5 <= den4;
      pix5 <= pix4;

      dout.sat <= sat5;
      dout.den <= den5;
      dout.rem <= bit_lo ? rem5 - 43'(den5) : rem5;
      dout.quo <= {32'd0, q1_5, bit_lo};
      dout.pix <= pix5;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rvs_divider.sv
// Restoring divider, one fractional quotient bit per stage.
// Produces the Q2.32 ratio of squared distances. Uses rvs_pkg.
`default_nettype none
module rvs_divider (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire rvs_pkg::div_t din,
  output rvs_pkg::div_t      dout
);

  rvs_pkg::div_t stg [rvs_pkg::DIV_STAGES];
  rvs_pkg::div_t nxt [rvs_pkg::DIV_STAGES];

  always_comb begin
    for (int i = 0; i < rvs_pkg::DIV_STAGES; i++) begin
      logic [42:0] shifted;
      rvs_pkg::div_t src;
      src = (i == 0) ? din : stg[(i == 0) ? 0 : i - 1];
      shifted = {src.rem[41:0], 1'b0};
      nxt[i] = src;
      if (shifted >= 43'(src.den)) begin
        nxt[i].rem = shifted - 43'(src.den);
        nxt[i].quo = {src.quo[32:0], 1'b1};
      end else begin
        nxt[i].rem = shifted;
        nxt[i].quo = {src.quo[32:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rvs_pkg::DIV_STAGES; i++) begin
        stg[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < rvs_pkg::DIV_STAGES; i++) begin
        stg[i] <= nxt[i];
      end
    end
  end

  assign dout = stg[rvs_pkg::DIV_STAGES - 1];

endmodule
`default_nettype wire

FILE: sv/rvs_sqrt.sv
// Digit-by-digit square root, one result bit per stage.
// Turns the Q2.32 squared ratio into d in Q1.16. Uses rvs_pkg.
`default_nettype none
module rvs_sqrt (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire rvs_pkg::div_t din,
  output rvs_pkg::sqr_t      dout
);

  rvs_pkg::sqr_t start;
  rvs_pkg::sqr_t stg [rvs_pkg::SQRT_STAGES];
  rvs_pkg::sqr_t nxt [rvs_pkg::SQRT_STAGES];

  always_comb begin
    start.valid = din.valid;
    start.sat   = din.sat;
    start.rad   = din.quo;
    start.rem   = 19'd0;
    start.root  = 17'd0;
    start.pix   = din.pix;
    for (int i = 0; i < rvs_pkg::SQRT_STAGES; i++) begin
      logic [20:0] remx;
      logic [20:0] trial;
      rvs_pkg::sqr_t src;
      src = (i == 0) ? start : stg[(i == 0) ? 0 : i - 1];
      remx  = {src.rem, src.rad[33:32]};
      trial = {2'b00, src.root[16:0], 2'b01};
      nxt[i] = src;
      nxt[i].rad = {src.rad[31:0], 2'b00};
      if (remx >= trial) begin
        nxt[i].rem  = 19'(remx - trial);
        nxt[i].root = {src.root[15:0], 1'b1};
      end else begin
        nxt[i].rem  = remx[18:0];
        nxt[i].root = {src.root[15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rvs_pkg::SQRT_STAGES; i++) begin
        stg[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < rvs_pkg::SQRT_STAGES; i++) begin
        stg[i] <= nxt[i];
      end
    end
  end

  assign dout = stg[rvs_pkg::SQRT_STAGES - 1];

endmodule
`default_nettype wire

FILE: sv/rvs_gain.sv
// Knee, strength scaling and per-channel gain multiply with the output
// register. Uses rvs_pkg.
`default_nettype none
module rvs_gain (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic [6:0]    strength,
  input  wire rvs_pkg::sqr_t din,
  output logic               result_valid,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic [7:0]         out_alpha
);

  logic [16:0] t, diff, sub;
  logic [24:0] r_sc, g_sc, b_sc;

  logic          v1, v2, v3;
  logic [23:0]   x1;
  logic [47:0]   p2;
  logic [16:0]   gain3;
  rvs_pkg::pix_t pix1, pix2, pix3;

  always_comb begin
    diff = din.root - rvs_pkg::HALF_Q16;
    if (din.sat) begin
      t = rvs_pkg::ONE_Q16;
    end else if (din.root <= rvs_pkg::HALF_Q16) begin
      t = 17'd0;
    end else if (diff > rvs_pkg::ONE_Q16) begin
      t = rvs_pkg::ONE_Q16;
    end else begin
      t = diff;
    end
    sub  = p2[rvs_pkg::RECIP_SHIFT +: 17];
    r_sc = 25'(pix3.red)   * 25'(gain3) + 25'h8000;
    g_sc = 25'(pix3.green) * 25'(gain3) + 25'h8000;
    b_sc = 25'(pix3.blue)  * 25'(gain3) + 25'h8000;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      v1 <= din.valid;
      v2 <= v1;
      v3 <= v2;
      result_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= 24'(strength) * 24'(t) + rvs_pkg::ROUND_PCT;
      pix1 <= din.pix;
      p2 <= 48'(x1) * 48'(rvs_pkg::RECIP_100);
      pix2 <= pix1;
      gain3 <= (sub >= rvs_pkg::ONE_Q16) ? 17'd0 : rvs_pkg::ONE_Q16 - sub;
      pix3 <= pix2;
      out_red   <= r_sc[23:16];
      out_green <= g_sc[23:16];
      out_blue  <= b_sc[23:16];
      out_alpha <= pix3.alpha;
    end
  end

endmodule
`default_nettype wire
